[hw/rtl/ais_enc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AIS encoder package
// Shared item types, bit source codes, framing constants and the header bit function.
// ----------------------------------------------------------------------------
package ais_enc_pkg;

  localparam logic        OP_START   = 1'b0;
  localparam logic        OP_DATA    = 1'b1;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  TRAIN_BYTE = 8'h55;
  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;

  // Header is one zero byte, three training bytes and the opening flag.
  localparam int          HDR_BITS   = 40;
  localparam int          CNT_W      = 6;
  // Bits before this position go out without NRZI coding.
  localparam int          CODE_START = 8;
  localparam int          POS_W      = 4;
  // Five ones in a row force a stuffed zero.
  localparam logic [2:0]  ONES_LIMIT = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0] symbol_index;
    logic       line_level;
    logic       end_of_run;
    logic       end_of_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    SRC_HDR,
    SRC_DATA,
    SRC_CRC,
    SRC_FLAG,
    SRC_STUFF,
    SRC_FINAL
  } src_t;

  typedef struct packed {
    logic             start;
    logic             load;
    logic             step;
    src_t             src;
    logic [CNT_W-1:0] idx;
    logic             run_end;
    logic             frame_end;
  } cmd_t;

  typedef struct packed {
    logic can_step;
    logic stuff_need;
    logic in_frame;
  } status_t;

  // Raw header bit at a position of the header, each byte MSB first.
  function automatic logic hdr_bit(input logic [CNT_W-1:0] idx);
    logic b;
    if (idx < CNT_W'(8)) begin
      b = 1'b0;
    end else if (idx < CNT_W'(32)) begin
      b = TRAIN_BYTE[~idx[2:0]];
    end else begin
      b = FLAG_BYTE[~idx[2:0]];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ais_enc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AIS encoder controller
// Sequences header, data, CRC, stuffing and flag bits, one push per cycle while not stalled.
// ----------------------------------------------------------------------------
module ais_enc_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  ais_enc_pkg::in_item_t in_item,
  input  ais_enc_pkg::status_t  status,
  output ais_enc_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DATA,
    S_CRC,
    S_FLAG,
    S_STUFF,
    S_FINAL
  } state_t;

  localparam int W = ais_enc_pkg::CNT_W;

  state_t         state_r, state_nxt;
  logic [W-1:0]   cnt_r, cnt_nxt;
  logic           last_r, last_nxt;
  logic           crc_phase_r, crc_phase_nxt;
  logic           accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    crc_phase_nxt = crc_phase_r;
    cmd           = '0;
    cmd.idx       = cnt_r;
    cmd.src       = ais_enc_pkg::SRC_STUFF;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.operation == ais_enc_pkg::OP_START) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_HDR;
          end else if (status.in_frame) begin
            cmd.load      = 1'b1;
            last_nxt      = in_item.is_last;
            crc_phase_nxt = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = S_DATA;
          end
        end
      end
      S_HDR: begin
        cmd.src     = ais_enc_pkg::SRC_HDR;
        cmd.step    = status.can_step;
        cmd.run_end = (cnt_r == W'(ais_enc_pkg::HDR_BITS - 1));
        if (status.can_step) begin
          cnt_nxt = cnt_r + W'(1);
          if (cmd.run_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DATA: begin
        cmd.src     = ais_enc_pkg::SRC_DATA;
        cmd.step    = status.can_step;
        cmd.run_end = (cnt_r == W'(7)) && !last_r && !status.stuff_need;
        if (status.can_step) begin
          cnt_nxt = cnt_r + W'(1);
          if (status.stuff_need) begin
            state_nxt = S_STUFF;
          end else if (cnt_r == W'(7)) begin
            crc_phase_nxt = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = last_r ? S_CRC : S_IDLE;
          end
        end
      end
      S_CRC: begin
        cmd.src  = ais_enc_pkg::SRC_CRC;
        cmd.step = status.can_step;
        if (status.can_step) begin
          cnt_nxt = cnt_r + W'(1);
          if (status.stuff_need) begin
            state_nxt = S_STUFF;
          end else if (cnt_r == W'(15)) begin
            cnt_nxt   = '0;
            state_nxt = S_FLAG;
          end
        end
      end
      S_STUFF: begin
        cmd.src     = ais_enc_pkg::SRC_STUFF;
        cmd.step    = status.can_step;
        cmd.run_end = !crc_phase_r && (cnt_r == W'(8)) && !last_r;
        if (status.can_step) begin
          if (!crc_phase_r) begin
            if (cnt_r == W'(8)) begin
              crc_phase_nxt = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = last_r ? S_CRC : S_IDLE;
            end else begin
              state_nxt = S_DATA;
            end
          end else begin
            if (cnt_r == W'(16)) begin
              cnt_nxt   = '0;
              state_nxt = S_FLAG;
            end else begin
              state_nxt = S_CRC;
            end
          end
        end
      end
      S_FLAG: begin
        cmd.src  = ais_enc_pkg::SRC_FLAG;
        cmd.step = status.can_step;
        if (status.can_step) begin
          cnt_nxt = cnt_r + W'(1);
          if (cnt_r == W'(7)) begin
            state_nxt = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        cmd.src       = ais_enc_pkg::SRC_FINAL;
        cmd.step      = status.can_step;
        cmd.run_end   = 1'b1;
        cmd.frame_end = 1'b1;
        if (status.can_step) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      crc_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      crc_phase_r <= crc_phase_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ais_enc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AIS encoder datapath
// CRC, stuffing count, NRZI levels, symbol build and the output register.
// ----------------------------------------------------------------------------
module ais_enc_dpath (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ais_enc_pkg::in_item_t  in_item,
  input  ais_enc_pkg::cmd_t      cmd,
  output ais_enc_pkg::status_t   status,
  output logic                   out_valid,
  input  wire                    out_stall,
  output ais_enc_pkg::out_item_t out_item
);

  localparam int PW = ais_enc_pkg::POS_W;

  logic [15:0]   crc_r;
  logic [2:0]    ones_r;
  logic          older_r;
  logic          held_r;
  logic [PW-1:0] pos_r;
  logic          in_frame_r;
  logic [7:0]    data_r;
  logic          out_valid_r;
  ais_enc_pkg::out_item_t out_r;

  logic raw;
  logic level;
  logic emits;
  logic is_final;
  logic fb;

  assign is_final = (cmd.src == ais_enc_pkg::SRC_FINAL);

  always_comb begin
    case (cmd.src)
      ais_enc_pkg::SRC_HDR:  raw = ais_enc_pkg::hdr_bit(cmd.idx);
      ais_enc_pkg::SRC_DATA: raw = data_r[cmd.idx[2:0]];
      ais_enc_pkg::SRC_CRC:  raw = ~crc_r[15];
      ais_enc_pkg::SRC_FLAG: raw = ais_enc_pkg::FLAG_BYTE[~cmd.idx[2:0]];
      default:               raw = 1'b0;
    endcase

    if (is_final) begin
      level = held_r;
    end else if (pos_r < PW'(ais_enc_pkg::CODE_START)) begin
      level = raw;
    end else begin
      // A one keeps the line level and a zero toggles it.
      level = raw ? held_r : ~held_r;
    end

    emits = is_final || (pos_r != '0);
    fb    = crc_r[15] ^ raw;

    status.can_step   = !out_valid_r || !out_stall;
    status.stuff_need = ((cmd.src == ais_enc_pkg::SRC_DATA) ||
                         (cmd.src == ais_enc_pkg::SRC_CRC)) &&
                        raw && (ones_r == ais_enc_pkg::ONES_LIMIT);
    status.in_frame   = in_frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= ais_enc_pkg::CRC_INIT;
      ones_r      <= '0;
      older_r     <= 1'b0;
      held_r      <= 1'b0;
      pos_r       <= '0;
      in_frame_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new symbol refills the register; otherwise a taken symbol empties it.
      if (cmd.step && emits) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.start) begin
        crc_r      <= ais_enc_pkg::CRC_INIT;
        ones_r     <= '0;
        older_r    <= 1'b0;
        held_r     <= 1'b0;
        pos_r      <= '0;
        in_frame_r <= 1'b1;
      end
      if (cmd.step) begin
        if (is_final) begin
          in_frame_r <= 1'b0;
        end else begin
          older_r <= held_r;
          held_r  <= level;
          if (pos_r < PW'(ais_enc_pkg::CODE_START)) begin
            pos_r <= pos_r + PW'(1);
          end
        end
        case (cmd.src)
          ais_enc_pkg::SRC_DATA: begin
            crc_r <= {crc_r[14:0], 1'b0} ^ (fb ? ais_enc_pkg::CRC_POLY : 16'h0000);
          end
          ais_enc_pkg::SRC_CRC: begin
            crc_r <= {crc_r[14:0], 1'b0};
          end
          default: begin
          end
        endcase
        if ((cmd.src == ais_enc_pkg::SRC_DATA) || (cmd.src == ais_enc_pkg::SRC_CRC)) begin
          if (!raw || status.stuff_need) begin
            ones_r <= '0;
          end else begin
            ones_r <= ones_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_item.data_byte;
    end
    if (cmd.step && emits) begin
      out_r.symbol_index <= {older_r, held_r, level};
      out_r.line_level   <= held_r;
      out_r.end_of_run   <= cmd.run_end;
      out_r.end_of_frame <= cmd.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[hw/rtl/ais_hdlc_frame_symbol_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AIS HDLC frame symbol encoder
// Builds an HDLC frame with CRC-16, bit stuffing and NRZI coding and emits
// one three-bit symbol index per coded bit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | operation, data_byte, is_last
//  out_    | output    | out_valid/out_stall| symbol_index, line_level,
//          |           |                    | end_of_run, end_of_frame
//
// One bit is pushed per cycle through a single shared bit datapath while the
// output is not stalled. The accepting cycle pushes nothing. A start item
// pushes the 40 header bits, a data byte its 8 bits and up to two stuffed
// zeros, the last byte of a message its data, CRC, stuffed zeros, end flag
// and the closing symbol; a data byte outside a frame is taken and dropped.
// in_stall is high from the cycle after a start item or an in-frame data byte
// is accepted until its last bit has been pushed.
// Reset is synchronous and active low; it clears the frame state and the
// output valid flag. A high out_stall holds the pending symbol and pauses the
// bit sequencer until that symbol is taken.
//
// The controller walks through header, data, CRC, stuffing and flag phases
// and hands a bit source and index to the datapath each cycle. The datapath
// keeps the CRC, the run of ones, the two most recent line levels and the
// frame position, and it builds each symbol one bit late, once the level of
// the following bit is known. The frame's last symbol reuses its own level
// as the look-ahead.
// ----------------------------------------------------------------------------
module ais_hdlc_frame_symbol_encoder (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  ais_enc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  wire                    out_stall,
  output ais_enc_pkg::out_item_t out_item
);

  ais_enc_pkg::cmd_t    cmd;
  ais_enc_pkg::status_t status;

  // Sequencer for the bit phases of a frame.
  ais_enc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .status   (status),
    .cmd      (cmd)
  );

  // Coding state and output register.
  ais_enc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An accepted start item always keeps the input side busy for its header.
  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.operation == ais_enc_pkg::OP_START)
    |=> in_stall)
    else $error("start item did not occupy the encoder");

  // The middle bit of a symbol is the coded level that travels with it.
  a_level_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.symbol_index[1] == out_item.line_level))
    else $error("symbol index and line level disagree");

  // The closing symbol of a frame also closes the run of its item.
  a_frame_end_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_frame |-> out_item.end_of_run)
    else $error("frame end without run end");

  // No item is taken while the sequencer still pushes bits.
  a_no_step_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> in_stall)
    else $error("bit pushed while input side idle");

endmodule
`default_nettype wire
